// ----- design/lob_pkg.sv -----
// lob_pkg: shared constants, record layouts, controller states and datapath ops
// for the limit order book core; no dependencies
package lob_pkg;

   // sizing
   localparam int ORDER_SLOTS  = 4096;
   localparam int PRICE_LEVELS = 256;
   localparam int SLOT_W       = $clog2(ORDER_SLOTS);
   localparam int HWM_W        = SLOT_W + 1;
   localparam int LVL_W        = $clog2(PRICE_LEVELS);
   localparam int CNT_W        = LVL_W + 1;
   localparam int DEPTH_W      = 9;
   localparam int CMP_W        = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
   localparam int KIND_W       = 3;
   localparam int ID_W         = 32;
   localparam int PX_W         = 31;

   localparam logic [PX_W-1:0] VOL_MAX = '1;

   // message kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXEC   = 3'd4;

   typedef struct packed {
      logic            live;
      logic [ID_W-1:0] id;
      logic [PX_W-1:0] price;
      logic [PX_W-1:0] size;
      logic            side;
   } order_entry_type;

   typedef struct packed {
      logic [PX_W-1:0] price;
      logic [PX_W-1:0] vol;
   } level_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISP, ST_OS_RD, ST_OS_CHK, ST_OPICK, ST_LS_RD, ST_LS_CHK,
      ST_LDEC, ST_ORD_WR, ST_LV_UPD, ST_INS_RD, ST_INS_WR, ST_INS_NEW,
      ST_REM_RD, ST_REM_WR, ST_REM_END, ST_SUM_INIT, ST_SUM_RD, ST_SUM_ACC,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DISP, OP_OS_RD, OP_OS_CHK, OP_OPICK, OP_LS_RD,
      OP_LS_CHK, OP_LDEC, OP_ORD_WR, OP_LV_UPD, OP_INS_RD, OP_INS_WR,
      OP_INS_NEW, OP_REM_RD, OP_REM_WR, OP_REM_END, OP_SUM_INIT, OP_SUM_RD,
      OP_SUM_ACC, OP_DONE
   } dp_op_type;

   typedef struct packed {
      logic is_add;
      logic is_reduce;
      logic add_ign;
      logic hwm_zero;
      logic os_hit;
      logic os_last;
      logic o_ok;
      logic ls_at_end;
      logic ls_stop;
      logic lmatch;
      logic lfull;
      logic lrm;
      logic sh_end;
      logic sum_end;
   } dp_status_type;

   // saturating volume add
   function automatic logic [PX_W-1:0] sat_add(input logic [PX_W-1:0] a,
                                               input logic [PX_W-1:0] b);
      logic [PX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PX_W] ? VOL_MAX : s[PX_W-1:0];
   endfunction

endpackage

// ----- design/lob_ram.sv -----
// lob_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/lob_ctrl.sv -----
// lob_ctrl: message sequencer for the order book
// depends on lob_pkg
module lob_ctrl import lob_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_op_type     op,
   output logic          busy,
   output logic          rsp_valid
);
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISP;
         end
         ST_DISP: begin
            if ((status.is_add && !status.add_ign) || status.is_reduce) begin
               state_in = status.hwm_zero ? ST_OPICK : ST_OS_RD;
            end else begin
               state_in = ST_SUM_INIT;
            end
         end
         ST_OS_RD:  state_in = ST_OS_CHK;
         ST_OS_CHK: state_in = (status.os_hit || status.os_last) ? ST_OPICK : ST_OS_RD;
         ST_OPICK:  state_in = status.o_ok ? ST_LS_RD : ST_SUM_INIT;
         ST_LS_RD:  state_in = status.ls_at_end ? ST_LDEC : ST_LS_CHK;
         ST_LS_CHK: state_in = status.ls_stop ? ST_LDEC : ST_LS_RD;
         ST_LDEC: begin
            if (status.is_add && !status.lmatch && status.lfull) state_in = ST_SUM_INIT;
            else state_in = ST_ORD_WR;
         end
         ST_ORD_WR: begin
            if (status.is_add) begin
               state_in = status.lmatch ? ST_LV_UPD : ST_INS_RD;
            end else if (!status.lmatch) begin
               state_in = ST_SUM_INIT;
            end else begin
               state_in = status.lrm ? ST_REM_RD : ST_LV_UPD;
            end
         end
         ST_LV_UPD:   state_in = ST_SUM_INIT;
         ST_INS_RD:   state_in = status.sh_end ? ST_INS_NEW : ST_INS_WR;
         ST_INS_WR:   state_in = ST_INS_RD;
         ST_INS_NEW:  state_in = ST_SUM_INIT;
         ST_REM_RD:   state_in = status.sh_end ? ST_REM_END : ST_REM_WR;
         ST_REM_WR:   state_in = ST_REM_RD;
         ST_REM_END:  state_in = ST_SUM_INIT;
         ST_SUM_INIT: state_in = ST_SUM_RD;
         ST_SUM_RD:   state_in = status.sum_end ? ST_DONE : ST_SUM_ACC;
         ST_SUM_ACC:  state_in = ST_SUM_RD;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath commands and handshake outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      op        = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            op   = start ? OP_LOAD : OP_NONE;
         end
         ST_DISP:     op = OP_DISP;
         ST_OS_RD:    op = OP_OS_RD;
         ST_OS_CHK:   op = OP_OS_CHK;
         ST_OPICK:    op = OP_OPICK;
         ST_LS_RD:    op = OP_LS_RD;
         ST_LS_CHK:   op = OP_LS_CHK;
         ST_LDEC:     op = OP_LDEC;
         ST_ORD_WR:   op = OP_ORD_WR;
         ST_LV_UPD:   op = OP_LV_UPD;
         ST_INS_RD:   op = OP_INS_RD;
         ST_INS_WR:   op = OP_INS_WR;
         ST_INS_NEW:  op = OP_INS_NEW;
         ST_REM_RD:   op = OP_REM_RD;
         ST_REM_WR:   op = OP_REM_WR;
         ST_REM_END:  op = OP_REM_END;
         ST_SUM_INIT: op = OP_SUM_INIT;
         ST_SUM_RD:   op = OP_SUM_RD;
         ST_SUM_ACC:  op = OP_SUM_ACC;
         ST_DONE: begin
            op        = OP_DONE;
            rsp_valid = 1'b1;
         end
         default: op = OP_NONE;
      endcase
   end
endmodule

// ----- design/lob_dp.sv -----
// lob_dp: order table, per-side sorted level tables, scan counters and sums
// depends on lob_pkg and lob_ram
module lob_dp import lob_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_op_type           op,
   output dp_status_type       status,
   input  logic                csr_wr_en,
   input  logic [DEPTH_W-1:0]  csr_wr_data,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ID_W-1:0]     req_msg_id,
   input  logic [PX_W-1:0]     req_price,
   input  logic [PX_W-1:0]     req_size,
   input  logic                req_side,
   output logic [PX_W-1:0]     rsp_best_bid,
   output logic [PX_W-1:0]     rsp_best_ask,
   output logic [PX_W-1:0]     rsp_bid_volume_best,
   output logic [PX_W-1:0]     rsp_ask_volume_best,
   output logic [PX_W-1:0]     rsp_bid_depth,
   output logic [PX_W-1:0]     rsp_ask_depth,
   output logic                rsp_best_changed,
   output logic                rsp_book_valid,
   output logic                rsp_dropped
);
   // control registers
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0]   cnt_b_ff, cnt_b_in, cnt_a_ff, cnt_a_in;
   logic [HWM_W-1:0]   hwm_ff, hwm_in;
   logic [PX_W-1:0]    prev_b_ff, prev_b_in, prev_a_ff, prev_a_in;
   // message and work registers
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [PX_W-1:0]    price_ff, price_in, size_ff, size_in;
   logic               side_ff, side_in;
   logic               dropped_ff, dropped_in;
   logic [HWM_W-1:0]   oidx_ff, oidx_in;
   logic               found_ff, found_in, free_ff, free_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in, free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]  wslot_ff, wslot_in;
   logic               grow_ff, grow_in;
   logic [PX_W-1:0]    e_price_ff, e_price_in, e_size_ff, e_size_in;
   logic               e_side_ff, e_side_in;
   logic               sel_side_ff, sel_side_in;
   logic [PX_W-1:0]    sel_price_ff, sel_price_in, delta_ff, delta_in;
   logic [CNT_W-1:0]   lidx_ff, lidx_in, sh_idx_ff, sh_idx_in;
   logic               lmatch_ff, lmatch_in;
   logic [PX_W-1:0]    lvol_ff, lvol_in;
   logic [CMP_W-1:0]   sidx_ff, sidx_in;
   logic [PX_W-1:0]    acc_b_ff, acc_b_in, acc_a_ff, acc_a_in;
   logic [PX_W-1:0]    best_b_ff, best_b_in, best_a_ff, best_a_in;
   logic [PX_W-1:0]    bvol_b_ff, bvol_b_in, bvol_a_ff, bvol_a_in;

   // memory ports
   order_entry_type ord_rd, ord_wr;
   level_entry_type lvb_rd, lva_rd, lv_sel, lvl_wr;
   logic            lvl_we;
   logic [LVL_W-1:0] lvl_rd_addr, lvl_wr_addr;

   // decode and compares
   logic             is_add, is_reduce, o_ok, better, ord_rm;
   logic [CNT_W-1:0] cnt_sel, sh_m1, sh_p1;
   logic [CMP_W-1:0] dl_x, cb_x, ca_x, lim_b, lim_a, max_lim;
   logic [PX_W-1:0]  upd_vol;

   lob_ram #(.WIDTH($bits(order_entry_type)), .DEPTH(ORDER_SLOTS)) u_ord_ram (
      .clock(clock), .wr_en(op == OP_ORD_WR), .wr_addr(wslot_ff), .wr_data(ord_wr),
      .rd_addr(oidx_ff[SLOT_W-1:0]), .rd_data(ord_rd)
   );
   lob_ram #(.WIDTH($bits(level_entry_type)), .DEPTH(PRICE_LEVELS)) u_bid_ram (
      .clock(clock), .wr_en(lvl_we && sel_side_ff), .wr_addr(lvl_wr_addr),
      .wr_data(lvl_wr), .rd_addr(lvl_rd_addr), .rd_data(lvb_rd)
   );
   lob_ram #(.WIDTH($bits(level_entry_type)), .DEPTH(PRICE_LEVELS)) u_ask_ram (
      .clock(clock), .wr_en(lvl_we && !sel_side_ff), .wr_addr(lvl_wr_addr),
      .wr_data(lvl_wr), .rd_addr(lvl_rd_addr), .rd_data(lva_rd)
   );

   // message decode and side selection
   assign is_add    = (kind_ff == KIND_ADD);
   assign is_reduce = (kind_ff == KIND_CANCEL) || (kind_ff == KIND_DELETE) ||
                      (kind_ff == KIND_EXEC);
   assign cnt_sel   = sel_side_ff ? cnt_b_ff : cnt_a_ff;
   assign lv_sel    = sel_side_ff ? lvb_rd : lva_rd;
   assign better    = sel_side_ff ? (lv_sel.price > sel_price_ff)
                                  : (lv_sel.price < sel_price_ff);
   assign o_ok      = is_add ? (found_ff || free_ff || (hwm_ff != HWM_W'(ORDER_SLOTS)))
                             : found_ff;
   assign sh_m1     = sh_idx_ff - CNT_W'(1);
   assign sh_p1     = sh_idx_ff + CNT_W'(1);
   assign ord_rm    = (e_size_ff <= delta_ff);
   assign upd_vol   = is_add ? sat_add(lvol_ff, delta_ff) : (lvol_ff - delta_ff);

   // depth limits per side
   assign dl_x    = CMP_W'(depth_ff);
   assign cb_x    = CMP_W'(cnt_b_ff);
   assign ca_x    = CMP_W'(cnt_a_ff);
   assign lim_b   = (dl_x != '0 && dl_x < cb_x) ? dl_x : cb_x;
   assign lim_a   = (dl_x != '0 && dl_x < ca_x) ? dl_x : ca_x;
   assign max_lim = (lim_b > lim_a) ? lim_b : lim_a;

   // status to the controller
   always_comb begin
      status.is_add    = is_add;
      status.is_reduce = is_reduce;
      status.add_ign   = (price_ff == '0) || (size_ff == '0);
      status.hwm_zero  = (hwm_ff == '0);
      status.os_hit    = ord_rd.live && (ord_rd.id == id_ff);
      status.os_last   = ((oidx_ff + HWM_W'(1)) == hwm_ff);
      status.o_ok      = o_ok;
      status.ls_at_end = (lidx_ff == cnt_sel);
      status.ls_stop   = !better;
      status.lmatch    = lmatch_ff;
      status.lfull     = (cnt_sel == CNT_W'(PRICE_LEVELS));
      status.lrm       = (lvol_ff <= delta_ff);
      status.sh_end    = is_add ? (sh_idx_ff == lidx_ff) : (sh_p1 == cnt_sel);
      status.sum_end   = (sidx_ff == max_lim);
   end

   // level table addressing
   always_comb begin
      lvl_we      = 1'b0;
      lvl_wr_addr = lidx_ff[LVL_W-1:0];
      lvl_wr      = lv_sel;
      case (op)
         OP_LS_RD:  lvl_rd_addr = lidx_ff[LVL_W-1:0];
         OP_INS_RD: lvl_rd_addr = sh_m1[LVL_W-1:0];
         OP_REM_RD: lvl_rd_addr = sh_p1[LVL_W-1:0];
         default:   lvl_rd_addr = sidx_ff[LVL_W-1:0];
      endcase
      case (op)
         OP_LV_UPD: begin
            lvl_we = 1'b1;
            lvl_wr = '{price: sel_price_ff, vol: upd_vol};
         end
         OP_INS_WR, OP_REM_WR: begin
            lvl_we      = 1'b1;
            lvl_wr_addr = sh_idx_ff[LVL_W-1:0];
         end
         OP_INS_NEW: begin
            lvl_we = 1'b1;
            lvl_wr = '{price: sel_price_ff, vol: delta_ff};
         end
         default: lvl_we = 1'b0;
      endcase
   end

   // order table write data
   always_comb begin
      if (is_add) begin
         ord_wr = '{live: 1'b1, id: id_ff, price: price_ff, size: size_ff, side: side_ff};
      end else begin
         ord_wr = '{live: !ord_rm, id: id_ff, price: e_price_ff,
                    size: e_size_ff - delta_ff, side: e_side_ff};
      end
   end

   // next values
   always_comb begin
      depth_in = csr_wr_en ? csr_wr_data : depth_ff;
      cnt_b_in = cnt_b_ff;      cnt_a_in = cnt_a_ff;
      hwm_in = hwm_ff;
      prev_b_in = prev_b_ff;    prev_a_in = prev_a_ff;
      kind_in = kind_ff;        id_in = id_ff;
      price_in = price_ff;      size_in = size_ff;     side_in = side_ff;
      dropped_in = dropped_ff;  oidx_in = oidx_ff;
      found_in = found_ff;      free_in = free_ff;
      slot_in = slot_ff;        free_slot_in = free_slot_ff;
      wslot_in = wslot_ff;      grow_in = grow_ff;
      e_price_in = e_price_ff;  e_size_in = e_size_ff; e_side_in = e_side_ff;
      sel_side_in = sel_side_ff; sel_price_in = sel_price_ff; delta_in = delta_ff;
      lidx_in = lidx_ff;        sh_idx_in = sh_idx_ff;
      lmatch_in = lmatch_ff;    lvol_in = lvol_ff;
      sidx_in = sidx_ff;
      acc_b_in = acc_b_ff;      acc_a_in = acc_a_ff;
      best_b_in = best_b_ff;    best_a_in = best_a_ff;
      bvol_b_in = bvol_b_ff;    bvol_a_in = bvol_a_ff;
      case (op)
         OP_LOAD: begin
            kind_in = req_kind;   id_in = req_msg_id;
            price_in = req_price; size_in = req_size; side_in = req_side;
            dropped_in = 1'b0;    found_in = 1'b0;    free_in = 1'b0;
            oidx_in = '0;
         end
         OP_DISP: begin
            if (kind_ff == KIND_CLEAR) begin
               cnt_b_in = '0;
               cnt_a_in = '0;
               hwm_in   = '0;
            end
         end
         // order table scan, first match or first free slot
         OP_OS_CHK: begin
            if (ord_rd.live && (ord_rd.id == id_ff)) begin
               found_in   = 1'b1;
               slot_in    = oidx_ff[SLOT_W-1:0];
               e_price_in = ord_rd.price;
               e_size_in  = ord_rd.size;
               e_side_in  = ord_rd.side;
            end else if (!ord_rd.live && !free_ff) begin
               free_in      = 1'b1;
               free_slot_in = oidx_ff[SLOT_W-1:0];
            end
            oidx_in = oidx_ff + HWM_W'(1);
         end
         OP_OPICK: begin
            lidx_in   = '0;
            lmatch_in = 1'b0;
            grow_in   = !found_ff && !free_ff;
            if (is_add) begin
               sel_side_in  = side_ff;
               sel_price_in = price_ff;
               delta_in     = size_ff;
               wslot_in     = found_ff ? slot_ff :
                              free_ff ? free_slot_ff : hwm_ff[SLOT_W-1:0];
               dropped_in   = !o_ok;
            end else begin
               sel_side_in  = e_side_ff;
               sel_price_in = e_price_ff;
               delta_in     = (kind_ff == KIND_DELETE) ? e_size_ff : size_ff;
               wslot_in     = slot_ff;
            end
         end
         // sorted level scan, stops at the first level not better
         OP_LS_CHK: begin
            if (better) begin
               lidx_in = lidx_ff + CNT_W'(1);
            end else begin
               lmatch_in = (lv_sel.price == sel_price_ff);
               lvol_in   = lv_sel.vol;
            end
         end
         OP_LDEC: begin
            if (is_add && !lmatch_ff && (cnt_sel == CNT_W'(PRICE_LEVELS))) begin
               dropped_in = 1'b1;
            end
         end
         OP_ORD_WR: begin
            if (is_add && grow_ff) hwm_in = hwm_ff + HWM_W'(1);
            sh_idx_in = is_add ? cnt_sel : lidx_ff;
         end
         OP_INS_WR: sh_idx_in = sh_m1;
         OP_REM_WR: sh_idx_in = sh_p1;
         OP_INS_NEW: begin
            if (sel_side_ff) cnt_b_in = cnt_b_ff + CNT_W'(1);
            else cnt_a_in = cnt_a_ff + CNT_W'(1);
         end
         OP_REM_END: begin
            if (sel_side_ff) cnt_b_in = cnt_b_ff - CNT_W'(1);
            else cnt_a_in = cnt_a_ff - CNT_W'(1);
         end
         // depth sums, both sides in step
         OP_SUM_INIT: begin
            sidx_in = '0;
            acc_b_in = '0;  acc_a_in = '0;
            best_b_in = '0; best_a_in = '0;
            bvol_b_in = '0; bvol_a_in = '0;
         end
         OP_SUM_ACC: begin
            if (sidx_ff < lim_b) begin
               acc_b_in = sat_add(acc_b_ff, lvb_rd.vol);
               if (sidx_ff == '0) begin
                  best_b_in = lvb_rd.price;
                  bvol_b_in = lvb_rd.vol;
               end
            end
            if (sidx_ff < lim_a) begin
               acc_a_in = sat_add(acc_a_ff, lva_rd.vol);
               if (sidx_ff == '0) begin
                  best_a_in = lva_rd.price;
                  bvol_a_in = lva_rd.vol;
               end
            end
            sidx_in = sidx_ff + CMP_W'(1);
         end
         OP_DONE: begin
            prev_b_in = best_b_ff;
            prev_a_in = best_a_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         cnt_b_ff  <= '0;
         cnt_a_ff  <= '0;
         hwm_ff    <= '0;
         prev_b_ff <= '0;
         prev_a_ff <= '0;
      end else begin
         depth_ff  <= depth_in;
         cnt_b_ff  <= cnt_b_in;
         cnt_a_ff  <= cnt_a_in;
         hwm_ff    <= hwm_in;
         prev_b_ff <= prev_b_in;
         prev_a_ff <= prev_a_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;       id_ff <= id_in;
      price_ff <= price_in;     size_ff <= size_in;     side_ff <= side_in;
      dropped_ff <= dropped_in; oidx_ff <= oidx_in;
      found_ff <= found_in;     free_ff <= free_in;
      slot_ff <= slot_in;       free_slot_ff <= free_slot_in;
      wslot_ff <= wslot_in;     grow_ff <= grow_in;
      e_price_ff <= e_price_in; e_size_ff <= e_size_in; e_side_ff <= e_side_in;
      sel_side_ff <= sel_side_in; sel_price_ff <= sel_price_in; delta_ff <= delta_in;
      lidx_ff <= lidx_in;       sh_idx_ff <= sh_idx_in;
      lmatch_ff <= lmatch_in;   lvol_ff <= lvol_in;
      sidx_ff <= sidx_in;
      acc_b_ff <= acc_b_in;     acc_a_ff <= acc_a_in;
      best_b_ff <= best_b_in;   best_a_ff <= best_a_in;
      bvol_b_ff <= bvol_b_in;   bvol_a_ff <= bvol_a_in;
   end

   // result fields
   assign rsp_best_bid        = best_b_ff;
   assign rsp_best_ask        = best_a_ff;
   assign rsp_bid_volume_best = bvol_b_ff;
   assign rsp_ask_volume_best = bvol_a_ff;
   assign rsp_bid_depth       = acc_b_ff;
   assign rsp_ask_depth       = acc_a_ff;
   assign rsp_best_changed    = (best_b_ff != prev_b_ff) || (best_a_ff != prev_a_ff);
   assign rsp_book_valid      = (cnt_b_ff != '0) && (cnt_a_ff != '0);
   assign rsp_dropped         = dropped_ff;

`ifndef NO_ASSERTIONS
   // level counts never pass the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_b_ff <= CNT_W'(PRICE_LEVELS)) && (cnt_a_ff <= CNT_W'(PRICE_LEVELS)))
      else $error("level count beyond table size");
   // fill mark never passes the order table size
   a_hwm_bound: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= HWM_W'(ORDER_SLOTS))
      else $error("order fill mark beyond table size");
   // outside a clear, a bid count moves by at most one per cycle
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (op != OP_DISP) |=> (cnt_b_ff == $past(cnt_b_ff) ||
                           cnt_b_ff == $past(cnt_b_ff) + CNT_W'(1) ||
                           cnt_b_ff + CNT_W'(1) == $past(cnt_b_ff)))
      else $error("bid level count jumped");
`endif
endmodule

// ----- design/limit_order_book_core.sv -----
// Limit order book core: one market message per transfer, one result each.
// Work per message grows with F order slots below the fill mark scanned, P levels walked past,
// S levels shifted on insert or remove, and D, the larger depth limit, summed over.
// busy is high until the result strobe and the next message is taken in the cycle after it;
// the receiver cannot stall. Synchronous reset clears level counts, fill mark and depth.
module limit_order_book_core import lob_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [ID_W-1:0]    req_msg_id,
   input  logic [PX_W-1:0]    req_price,
   input  logic [PX_W-1:0]    req_size,
   input  logic               req_side,
   output logic               rsp_valid,
   output logic [PX_W-1:0]    rsp_best_bid,
   output logic [PX_W-1:0]    rsp_best_ask,
   output logic [PX_W-1:0]    rsp_bid_volume_best,
   output logic [PX_W-1:0]    rsp_ask_volume_best,
   output logic [PX_W-1:0]    rsp_bid_depth,
   output logic [PX_W-1:0]    rsp_ask_depth,
   output logic               rsp_best_changed,
   output logic               rsp_book_valid,
   output logic               rsp_dropped,
   input  logic               csr_wr_en,
   input  logic [DEPTH_W-1:0] csr_wr_data
);
   dp_op_type     op;
   dp_status_type status;

   // sequencer
   lob_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status),
      .op(op), .busy(busy), .rsp_valid(rsp_valid)
   );

   // tables and arithmetic
   lob_dp u_dp (
      .clock(clock), .reset(reset), .op(op), .status(status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_kind(req_kind), .req_msg_id(req_msg_id), .req_price(req_price),
      .req_size(req_size), .req_side(req_side),
      .rsp_best_bid(rsp_best_bid), .rsp_best_ask(rsp_best_ask),
      .rsp_bid_volume_best(rsp_bid_volume_best),
      .rsp_ask_volume_best(rsp_ask_volume_best),
      .rsp_bid_depth(rsp_bid_depth), .rsp_ask_depth(rsp_ask_depth),
      .rsp_best_changed(rsp_best_changed), .rsp_book_valid(rsp_book_valid),
      .rsp_dropped(rsp_dropped)
   );
endmodule
